// ===== rtl/bounded_deque_sorted_list_unit_defines.svh =====
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define BDSL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define BDSL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BDSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdsl_pkg.sv =====
// Types and constants of the bounded deque with sorted insert.
package bdsl_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SORTED_INS = 3'd4;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP_RD,
        S_POP_CAP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_LIST_RD,
        S_LIST_EMIT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/bdsl_req_if.sv =====
// Request channel: operation and value with valid/ready handshake.
interface bdsl_req_if import bdsl_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

// ===== rtl/bdsl_rsp_if.sv =====
// Result channel: status, data, position, last mark and count with valid/ready.
interface bdsl_rsp_if import bdsl_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic [POS_W-1:0]    position;
    logic                last;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, output status, output data_out, output position,
        output last, output entry_count, input ready
    );
    modport sink (
        input valid, input status, input data_out, input position,
        input last, input entry_count, output ready
    );

endinterface

// ===== rtl/bounded_deque_sorted_list_unit.sv =====
// Top level of the bounded deque of signed Q16.16 values with sorted insert.
//
// req carries one request (operation, value); rsp returns its results.
// Every request gives one result with last set, except a list of a
// non-empty deque, which gives one result per entry, front first, the
// final one marked last. status reports ok, empty or full.
// The entries sit in a circular RAM with one write and one registered
// read port; one shared slot-address adder (front + offset, modulo
// CAPACITY) and one signed comparator serve every step of a small
// sequencer. A push writes the value at its end; a pop reads the end
// entry and then captures it; clear only resets front and count; a
// list reads and emits each entry; a reverse swaps entry pairs from
// both ends inward; a sorted insert scans for the insert point, shifts
// the entries from there one slot back, then writes the value. A full
// push or insert, an empty pop, reverse or list, and a one-entry
// reverse go straight to the result.
// req.ready is high only while the sequencer is idle. Results leave
// through an output register, so a request is taken while the last
// result still waits; a stalled rsp holds the sequencer at its next result.
// Reset empties the deque; the RAM contents are not cleared.
module bounded_deque_sorted_list_unit
    import bdsl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bdsl_req_if.sink   req,
    bdsl_rsp_if.source rsp
);

`include "bounded_deque_sorted_list_unit_defines.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_X    = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] OFF_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] OFF_ONE  = IDX_W'(1);

    // Sequencer and list state
    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   at_reg, at_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0] res_data_reg, res_data_next;
    logic [VALUE_W-1:0] tmp_reg, tmp_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VALUE_W-1:0]  out_data_reg, out_data_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                out_last_reg, out_last_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // RAM and shared units
    logic               ram_we;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;
    logic [IDX_W-1:0]   offset;
    logic [IDX_W:0]     slot_sum;
    logic [IDX_W-1:0]   slot_addr;
    logic               cmp_less;

    logic               req_fire;
    logic               res_free;
    logic               is_full;
    logic               is_empty;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   k_dec;
    logic [IDX_W-1:0]   hi_dec;
    logic               out_load;
    logic               list_last;

    assign req_fire  = req.valid && req.ready;
    assign res_free  = !out_valid_reg || rsp.ready;
    assign is_full   = (occ_reg == CAP_CNT);
    assign is_empty  = (occ_reg == '0);
    assign k_inc     = k_reg + 1'b1;
    assign k_dec     = k_reg - 1'b1;
    assign hi_dec    = hi_reg - 1'b1;
    assign list_last = (k_inc == occ_reg);

    // Shared slot-address unit: (front + offset) mod CAPACITY
    assign slot_sum  = {1'b0, front_reg} + {1'b0, offset};
    assign slot_addr = (slot_sum >= CAP_X) ? IDX_W'(slot_sum - CAP_X) : IDX_W'(slot_sum);

    // Shared signed comparator for the sorted-insert scan
    assign cmp_less = $signed(ram_rdata) < $signed(val_reg);

    bdsl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (ram_wdata),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.operation)
                        OP_PUSH_FRONT,
                        OP_PUSH_BACK:  state_next = is_full ? S_DONE : S_PUSH;
                        OP_POP_FRONT,
                        OP_POP_BACK:   state_next = is_empty ? S_DONE : S_POP_RD;
                        OP_SORTED_INS:
                        begin
                            if (is_full)
                                state_next = S_DONE;
                            else if (is_empty)
                                state_next = S_INSERT;
                            else
                                state_next = S_SCAN_RD;
                        end
                        OP_REVERSE:
                        begin
                            if (occ_reg > CNT_W'(1))
                                state_next = S_REV_RD_LO;
                            else
                                state_next = S_DONE;
                        end
                        OP_LIST:       state_next = is_empty ? S_DONE : S_LIST_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH:      state_next = S_DONE;
            S_POP_RD:    state_next = S_POP_CAP;
            S_POP_CAP:   state_next = S_DONE;
            S_SCAN_RD:   state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (!cmp_less)
                    state_next = S_SHIFT_RD;
                else if (k_inc == occ_reg)
                    state_next = S_INSERT;
                else
                    state_next = S_SCAN_RD;
            end
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = (k_dec == at_reg) ? S_INSERT : S_SHIFT_RD;
            S_INSERT:    state_next = S_DONE;
            S_REV_RD_LO: state_next = S_REV_RD_HI;
            S_REV_RD_HI: state_next = S_REV_WR_LO;
            S_REV_WR_LO: state_next = S_REV_WR_HI;
            S_REV_WR_HI:
            begin
                if (k_inc < CNT_W'(hi_dec))
                    state_next = S_REV_RD_LO;
                else
                    state_next = S_DONE;
            end
            S_LIST_RD:   state_next = S_LIST_EMIT;
            S_LIST_EMIT:
            begin
                if (res_free)
                    state_next = list_last ? S_IDLE : S_LIST_RD;
            end
            S_DONE:      state_next = res_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and output register loading
    always_comb
    begin
        op_next         = op_reg;
        val_next        = val_reg;
        front_next      = front_reg;
        occ_next        = occ_reg;
        k_next          = k_reg;
        at_next         = at_reg;
        hi_next         = hi_reg;
        status_next     = status_reg;
        res_data_next   = res_data_reg;
        tmp_next        = tmp_reg;
        offset          = k_reg[IDX_W-1:0];
        ram_we          = 1'b0;
        ram_wdata       = ram_rdata;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next       = req.operation;
                    val_next      = req.value;
                    status_next   = STATUS_OK;
                    res_data_next = '0;
                    k_next        = '0;
                    at_next       = '0;
                    hi_next       = IDX_W'(occ_reg - 1'b1);
                    case (req.operation)
                        OP_PUSH_FRONT,
                        OP_PUSH_BACK,
                        OP_SORTED_INS: if (is_full) status_next = STATUS_FULL;
                        OP_POP_FRONT,
                        OP_POP_BACK,
                        OP_REVERSE,
                        OP_LIST:       if (is_empty) status_next = STATUS_EMPTY;
                        OP_CLEAR:
                        begin
                            occ_next   = '0;
                            front_next = '0;
                        end
                        default:       status_next = STATUS_OK;
                    endcase
                end
            end
            // Single write at the chosen end
            S_PUSH:
            begin
                ram_we    = 1'b1;
                ram_wdata = val_reg;
                occ_next  = occ_reg + 1'b1;
                if (op_reg == OP_PUSH_FRONT)
                begin
                    offset     = OFF_LAST;
                    front_next = slot_addr;
                end
                else
                begin
                    offset = occ_reg[IDX_W-1:0];
                end
            end
            S_POP_RD:
            begin
                if (op_reg == OP_POP_FRONT)
                    offset = '0;
                else
                    offset = IDX_W'(occ_reg - 1'b1);
            end
            S_POP_CAP:
            begin
                res_data_next = ram_rdata;
                occ_next      = occ_reg - 1'b1;
                if (op_reg == OP_POP_FRONT)
                begin
                    offset     = OFF_ONE;
                    front_next = slot_addr;
                end
            end
            // Scan for the first entry not less than the value
            S_SCAN_RD:
            begin
                offset = k_reg[IDX_W-1:0];
            end
            S_SCAN_CMP:
            begin
                if (!cmp_less)
                begin
                    at_next = k_reg;
                    k_next  = occ_reg;
                end
                else
                begin
                    k_next = k_inc;
                    if (k_inc == occ_reg)
                        at_next = occ_reg;
                end
            end
            // Move entries at and after the insert point one slot back
            S_SHIFT_RD:
            begin
                offset = IDX_W'(k_dec);
            end
            S_SHIFT_WR:
            begin
                offset = k_reg[IDX_W-1:0];
                ram_we = 1'b1;
                k_next = k_dec;
            end
            S_INSERT:
            begin
                offset    = k_reg[IDX_W-1:0];
                ram_we    = 1'b1;
                ram_wdata = val_reg;
                occ_next  = occ_reg + 1'b1;
            end
            // Swap the entries at k (low) and hi
            S_REV_RD_LO:
            begin
                offset = k_reg[IDX_W-1:0];
            end
            S_REV_RD_HI:
            begin
                offset   = hi_reg;
                tmp_next = ram_rdata;
            end
            S_REV_WR_LO:
            begin
                offset = k_reg[IDX_W-1:0];
                ram_we = 1'b1;
            end
            S_REV_WR_HI:
            begin
                offset    = hi_reg;
                ram_we    = 1'b1;
                ram_wdata = tmp_reg;
                k_next    = k_inc;
                hi_next   = hi_dec;
            end
            S_LIST_RD:
            begin
                offset = k_reg[IDX_W-1:0];
            end
            S_LIST_EMIT:
            begin
                offset = k_reg[IDX_W-1:0];
                if (res_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = STATUS_OK;
                    out_data_next   = ram_rdata;
                    out_pos_next    = POS_W'(k_reg);
                    out_last_next   = list_last;
                    out_count_next  = COUNT_W'(occ_reg);
                    k_next          = k_inc;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = res_data_reg;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    out_count_next  = COUNT_W'(occ_reg);
                end
            end
            default:
            begin
                offset = k_reg[IDX_W-1:0];
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        k_reg          <= k_next;
        at_reg         <= at_next;
        hi_reg         <= hi_next;
        status_reg     <= status_next;
        res_data_reg   <= res_data_next;
        tmp_reg        <= tmp_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    // Ports
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.entry_count = out_count_reg;

    // Checks
    `BDSL_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CAP_CNT, "occupancy above capacity")
    `BDSL_ASSERT_IMPLY(a_shift_range,
        (state_reg == S_SHIFT_RD) || (state_reg == S_SHIFT_WR), k_reg > at_reg,
        "shift index at or below insert point")
    `BDSL_ASSERT_IMPLY(a_rev_order,
        (state_reg == S_REV_RD_LO) || (state_reg == S_REV_WR_HI),
        k_reg < CNT_W'(hi_reg), "reverse pointers crossed")
    `BDSL_ASSERT_NEXT(a_busy_after_req, req_fire, state_reg != S_IDLE,
        "sequencer idle after taking a request")

endmodule

// ===== rtl/bdsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
